### hw/rtl/bpba_pkg.sv
package bpba_pkg;

  localparam int MAP_BYTES   = 20;
  localparam int PAGE_BYTES  = 4096;
  localparam int TOTAL_PAGES = MAP_BYTES * 8;

  // bitmap address, scan pointer (holds MAP_BYTES itself) and page number widths
  localparam int MAP_AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int PTR_W   = $clog2(MAP_BYTES + 1);
  localparam int PAGE_W  = MAP_AW + 3;
  localparam int ADDR_W  = 20;
  localparam int PBYTE_W = $clog2(PAGE_BYTES + 1);

  localparam int IDX_W   = 8;
  localparam int CMP_W   = ($clog2(TOTAL_PAGES + 1) > IDX_W) ? $clog2(TOTAL_PAGES + 1) : IDX_W;

  localparam logic [7:0] BYTE_FULL    = 8'hff;
  localparam logic [7:0] BYTE_EMPTY   = 8'h00;
  localparam logic [7:0] TOP_BIT      = 8'h80;
  localparam logic [7:0] RESERVED_RST = 8'd8;

  // configuration port
  localparam int          CFG_AW       = 3;
  localparam int          CFG_DW       = 32;
  localparam logic        REG_RESERVED = 1'b0;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_MARK  = 2'd1,
    OP_ALLOC = 2'd2
  } op_e;

endpackage

### hw/rtl/bpba_req_if.sv
interface bpba_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] page_index;

  modport source (output valid, output op, output page_index, input ready);
  modport sink (input valid, input op, input page_index, output ready);
endinterface

### hw/rtl/bpba_rsp_if.sv
interface bpba_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [19:0] page_address;

  modport source (output valid, output ok, output page_address, input ready);
  modport sink (input valid, input ok, input page_address, output ready);
endinterface

### hw/rtl/boot_page_bitmap_allocator_core.sv
// path from accepted item to result: mark reads then writes its byte, a rejected mark or
// unknown op goes straight to the result, init writes each byte, alloc reads bytes to a free bit
// throughput: one item at a time, init and alloc step through the map a byte per cycle
// a new item is taken while the previous result still waits in the output register
// reset (async, active low) restores reserved_pages to 8 and, through per-byte
// valid flags, makes the map read as the first byte full and all others free
module boot_page_bitmap_allocator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  bpba_req_if.sink                            req_i,
  bpba_rsp_if.source                          rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpba_pkg::CFG_AW-1:0]         paddr,
  input  logic [bpba_pkg::CFG_DW-1:0]         pwdata,
  output logic [bpba_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int AW   = bpba_pkg::MAP_AW;
  localparam int CW   = bpba_pkg::PTR_W;
  localparam int PW   = bpba_pkg::PAGE_W;
  localparam int BW   = CW + 3;
  localparam int NW   = ((BW > 8) ? BW : 8) + 1;
  localparam int PRDW = ((PW + bpba_pkg::PBYTE_W) > bpba_pkg::ADDR_W) ?
                        (PW + bpba_pkg::PBYTE_W) : bpba_pkg::ADDR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e          state_q;
  logic [7:0]      reserved_q;
  logic [7:0]      idx_q;
  logic [CW-1:0]   ptr_q;
  logic            res_ok_q;
  logic [PW-1:0]   res_page_q;
  logic            out_vld_q;
  logic            out_ok_q;
  logic [bpba_pkg::ADDR_W-1:0] out_addr_q;

  // bitmap ram and its per-byte valid flags
  logic [7:0]      mem_q [bpba_pkg::MAP_BYTES];
  logic            vld_q [bpba_pkg::MAP_BYTES];
  logic [7:0]      rd_raw_q;
  logic            rd_hit_q;
  logic [AW-1:0]   rd_addr_q;
  logic            rd_pend_q;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data;
  logic            we;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;

  logic            req_acc;
  logic            out_free;
  logic            mark_in_range;
  logic            found;
  logic            scan_fail;
  logic [2:0]      first_bit;
  logic [AW-1:0]   mark_addr;
  logic [7:0]      init_byte;
  logic [NW-1:0]   base_pages;
  logic [NW-1:0]   n_pages;
  logic [NW-1:0]   fill;
  logic [PRDW-1:0] prod;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bpba_pkg::REG_RESERVED) ?
                  bpba_pkg::CFG_DW'(reserved_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= bpba_pkg::RESERVED_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == bpba_pkg::REG_RESERVED) begin
      reserved_q <= pwdata[7:0];
    end
  end

  assign req_acc   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_free  = !out_vld_q || rsp_o.ready;
  assign mark_addr = AW'(idx_q[7:3]);

  assign mark_in_range = bpba_pkg::CMP_W'(req_i.page_index) <
                         bpba_pkg::CMP_W'(bpba_pkg::TOTAL_PAGES);

  // unwritten bytes read as their reset contents
  assign rd_data = rd_hit_q ? rd_raw_q :
                   ((rd_addr_q == '0) ? bpba_pkg::BYTE_FULL : bpba_pkg::BYTE_EMPTY);

  always_comb begin
    first_bit = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!rd_data[7-k]) begin
        first_bit = 3'(k);
      end
    end
  end

  assign found     = (state_q == ST_SCAN) && rd_pend_q && (rd_data != bpba_pkg::BYTE_FULL);
  assign scan_fail = (state_q == ST_SCAN) && rd_pend_q && (rd_data == bpba_pkg::BYTE_FULL) &&
                     (rd_addr_q == AW'(bpba_pkg::MAP_BYTES - 1));

  // init pattern for the byte under ptr_q: full, empty or the top bits only
  assign base_pages = NW'({ptr_q, 3'b000});
  assign n_pages    = NW'(reserved_q);
  assign fill       = n_pages - base_pages;

  always_comb begin
    if (n_pages >= base_pages + NW'(8)) begin
      init_byte = bpba_pkg::BYTE_FULL;
    end else if (n_pages <= base_pages) begin
      init_byte = bpba_pkg::BYTE_EMPTY;
    end else begin
      init_byte = ~(bpba_pkg::BYTE_FULL >> fill[2:0]);
    end
  end

  // ram port control; reads run ahead of the scan check, so the write of a found
  // byte never meets a read of the same byte
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q[AW-1:0];
    we      = 1'b0;
    wr_addr = ptr_q[AW-1:0];
    wr_data = init_byte;
    case (state_q)
      ST_INIT: begin
        we = 1'b1;
      end
      ST_MARK_RD: begin
        rd_en   = 1'b1;
        rd_addr = mark_addr;
      end
      ST_MARK_WR: begin
        we      = 1'b1;
        wr_addr = mark_addr;
        wr_data = rd_data | (bpba_pkg::TOP_BIT >> idx_q[2:0]);
      end
      ST_SCAN: begin
        rd_en   = (ptr_q < CW'(bpba_pkg::MAP_BYTES));
        we      = found;
        wr_addr = rd_addr_q;
        wr_data = rd_data | (bpba_pkg::TOP_BIT >> first_bit);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bpba_pkg::MAP_BYTES; i++) begin
        vld_q[i] <= 1'b0;
      end
      rd_hit_q  <= 1'b0;
      rd_addr_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_pend_q <= rd_en;
      if (rd_en) begin
        rd_hit_q  <= vld_q[rd_addr];
        rd_addr_q <= rd_addr;
      end
    end
  end

  assign prod = PRDW'(res_page_q) * PRDW'(bpba_pkg::PAGE_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      ptr_q      <= '0;
      res_ok_q   <= 1'b0;
      res_page_q <= '0;
      out_vld_q  <= 1'b0;
      out_ok_q   <= 1'b0;
      out_addr_q <= '0;
    end else begin
      if (state_q == ST_RESP && out_free) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            idx_q      <= req_i.page_index;
            ptr_q      <= '0;
            res_ok_q   <= 1'b0;
            res_page_q <= '0;
            case (bpba_pkg::op_e'(req_i.op))
              bpba_pkg::OP_INIT: begin
                state_q <= ST_INIT;
              end
              bpba_pkg::OP_MARK: begin
                state_q <= mark_in_range ? ST_MARK_RD : ST_RESP;
              end
              bpba_pkg::OP_ALLOC: begin
                state_q <= ST_SCAN;
              end
              default: begin
                state_q <= ST_RESP;
              end
            endcase
          end
        end
        ST_INIT: begin
          if (ptr_q == CW'(bpba_pkg::MAP_BYTES - 1)) begin
            res_ok_q <= 1'b1;
            state_q  <= ST_RESP;
          end else begin
            ptr_q <= ptr_q + CW'(1);
          end
        end
        ST_MARK_RD: begin
          state_q <= ST_MARK_WR;
        end
        ST_MARK_WR: begin
          res_ok_q <= 1'b1;
          state_q  <= ST_RESP;
        end
        ST_SCAN: begin
          if (rd_en) begin
            ptr_q <= ptr_q + CW'(1);
          end
          if (found) begin
            res_ok_q   <= 1'b1;
            res_page_q <= {rd_addr_q, first_bit};
            state_q    <= ST_RESP;
          end else if (scan_fail) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_ok_q   <= res_ok_q;
            out_addr_q <= prod[bpba_pkg::ADDR_W-1:0];
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.ok           = out_ok_q;
  assign rsp_o.page_address = out_addr_q;

`ifndef SYNTHESIS
  a_no_rw_same_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && rd_en) |-> (wr_addr != rd_addr))
    else $error("bitmap read and write hit the same byte");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ok) |-> (rsp_o.page_address == '0))
    else $error("failed item carries a non-zero address");

  a_mark_data_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK_WR) |-> rd_pend_q)
    else $error("mark write without read data");

  a_alloc_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.op == bpba_pkg::OP_ALLOC) |=> (state_q == ST_SCAN && !rd_pend_q))
    else $error("alloc did not start a clean scan");
`endif

endmodule
